[sv/ogmc_pkg.sv]
// ----------------------------------------------------------------------------
// ogmc_pkg
// Shared types and constants for the occupancy grid closing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ogmc_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int MAX_RADIUS_DEF = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_RADIUS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_PASSES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_VALUE = 3'd4;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [8:0]        GRID_WIDTH_RST    = 9'd256;
	localparam logic [8:0]        GRID_HEIGHT_RST   = 9'd256;
	localparam logic [2:0]        CLOSE_RADIUS_RST  = 3'd1;
	localparam logic [3:0]        CLOSE_PASSES_RST  = 4'd1;
	localparam logic signed [7:0] OUTSIDE_VALUE_RST = 8'sd100;

	typedef struct packed {
		logic [1:0]        mode;
		logic [7:0]        cell_x;
		logic [7:0]        cell_y;
		logic signed [7:0] cell_value;
	} in_item_t;

	typedef struct packed {
		logic signed [7:0] read_value;
		logic              run_done;
	} out_item_t;

endpackage

`default_nettype wire

[sv/ogmc_ram.sv]
// ----------------------------------------------------------------------------
// ogmc_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogmc_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/occupancy_grid_morphological_close.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_morphological_close
// Grid store with cell write/read and an in-memory free-space closing run.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    ogmc_pkg::in_item_t
// out      output     out_valid/out_ready  ogmc_pkg::out_item_t
// cfg      input      cfg_we               cfg_index, cfg_data
//
// a cell write goes to the grid memory as it is taken; a cell read passes
// the registered memory read data and then the result register. a run does
// per pass and per half-pass a row sweep and a column sweep, each reading up
// to (2r+1) window entries per cell from one memory port, one a cycle, then
// a drain state. reset is asynchronous; the memories need no clearing.
// input is held off during a run, a pending read, or a stalled result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_morphological_close #(
	parameter int MAX_WIDTH  = ogmc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ogmc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_RADIUS = ogmc_pkg::MAX_RADIUS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire ogmc_pkg::in_item_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output ogmc_pkg::out_item_t                      out_data,
	input  wire logic                                cfg_we,
	input  wire logic [ogmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ogmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int PW    = $clog2(MAXD + MAX_RADIUS + 2);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
		return AW'(int'(y) * MAX_WIDTH) + AW'(x);
	endfunction

	// configuration
	logic [8:0]        grid_width_q, grid_height_q;
	logic [2:0]        close_radius_q;
	logic [3:0]        close_passes_q;
	logic signed [7:0] outside_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= ogmc_pkg::GRID_WIDTH_RST;
			grid_height_q   <= ogmc_pkg::GRID_HEIGHT_RST;
			close_radius_q  <= ogmc_pkg::CLOSE_RADIUS_RST;
			close_passes_q  <= ogmc_pkg::CLOSE_PASSES_RST;
			outside_value_q <= ogmc_pkg::OUTSIDE_VALUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogmc_pkg::REG_GRID_WIDTH:    grid_width_q    <= cfg_data;
				ogmc_pkg::REG_GRID_HEIGHT:   grid_height_q   <= cfg_data;
				ogmc_pkg::REG_CLOSE_RADIUS:  close_radius_q  <= cfg_data[2:0];
				ogmc_pkg::REG_CLOSE_PASSES:  close_passes_q  <= cfg_data[3:0];
				ogmc_pkg::REG_OUTSIDE_VALUE: outside_value_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic [PW-1:0] w_eff, h_eff, r_eff;
	logic          run_off;

	always_comb begin
		w_eff = (PW'(grid_width_q) > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(grid_width_q);
		h_eff = (PW'(grid_height_q) > PW'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : PW'(grid_height_q);
		r_eff = (PW'(close_radius_q) > PW'(MAX_RADIUS)) ? PW'(MAX_RADIUS) : PW'(close_radius_q);
		run_off = (r_eff == '0) || (close_passes_q == '0) || (w_eff == '0) || (h_eff == '0);
	end

	// control state
	state_t        state_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [PW-1:0] k_q;
	logic          col_q, erode_q, first_q, rd_pend_q, out_valid_q;
	logic [3:0]    pass_q;
	ogmc_pkg::out_item_t out_q;

	// pipeline stage after the memory read
	logic          v_s1, first_s1, last_s1, col_s1, inside_s1;
	logic [AW-1:0] waddr_s1;
	logic [7:0]    gval_q;
	logic          acc_q;

	logic          in_fire, inside_in;
	logic [AW-1:0] in_addr;
	logic [PW-1:0] c, n, hi, nc, lo_n;
	logic          last_k, last_x, last_y;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;

	assign in_ready  = (state_q == ST_IDLE) && !rd_pend_q && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign inside_in = (32'(in_data.cell_x) < MAX_WIDTH) && (32'(in_data.cell_y) < MAX_HEIGHT);
	assign in_addr   = cell_addr(YW'(in_data.cell_y), XW'(in_data.cell_x));

	always_comb begin
		c      = col_q ? PW'(y_q) : PW'(x_q);
		n      = col_q ? h_eff : w_eff;
		hi     = ((c + r_eff) < n) ? (c + r_eff) : (n - PW'(1));
		last_k = (k_q == hi);
		last_x = (PW'(x_q) == w_eff - PW'(1));
		last_y = (PW'(y_q) == h_eff - PW'(1));
		nx     = last_x ? '0 : XW'(x_q + XW'(1));
		ny     = last_x ? YW'(y_q + YW'(1)) : y_q;
		nc     = col_q ? PW'(ny) : PW'(nx);
		lo_n   = (nc >= r_eff) ? (nc - r_eff) : '0;
	end

	// memory ports
	logic          g_we, s_we;
	logic [AW-1:0] g_waddr, g_raddr, s_raddr;
	logic [7:0]    g_wdata, s_wdata, g_rdata, s_rdata;
	logic          mark, acc_new;
	logic [7:0]    gv, new_v;

	always_comb begin
		mark    = col_s1 ? s_rdata[0] : (erode_q ? (g_rdata != '0) : (g_rdata == '0));
		acc_new = (first_s1 ? 1'b0 : acc_q) | mark;
		gv      = first_s1 ? g_rdata : gval_q;
		if (!erode_q) begin
			new_v = acc_new ? 8'd0 : gv;
		end else begin
			new_v = ((gv == '0) && acc_new) ? outside_value_q : gv;
		end
		if (state_q == ST_IDLE) begin
			g_raddr = in_addr;
		end else if (col_q) begin
			g_raddr = cell_addr(y_q, x_q);
		end else begin
			g_raddr = cell_addr(y_q, k_q[XW-1:0]);
		end
		s_raddr = cell_addr(k_q[YW-1:0], x_q);
		if (state_q == ST_IDLE) begin
			g_we    = in_fire && (in_data.mode == ogmc_pkg::MODE_WRITE) && inside_in;
			g_waddr = in_addr;
			g_wdata = in_data.cell_value;
		end else begin
			g_we    = v_s1 && last_s1 && col_s1;
			g_waddr = waddr_s1;
			g_wdata = new_v;
		end
		s_we    = v_s1 && last_s1 && !col_s1;
		s_wdata = {7'd0, acc_new};
	end

	ogmc_ram #(.DEPTH(DEPTH), .AW(AW)) u_grid (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	ogmc_ram #(.DEPTH(DEPTH), .AW(AW)) u_scratch (
		.clk(clk), .we(s_we), .waddr(waddr_s1), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= first_q;
		last_s1   <= last_k;
		col_s1    <= col_q;
		waddr_s1  <= cell_addr(y_q, x_q);
		inside_s1 <= inside_in;
		if (v_s1) begin
			acc_q <= acc_new;
			if (first_s1) begin
				gval_q <= g_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			k_q         <= '0;
			col_q       <= 1'b0;
			erode_q     <= 1'b0;
			first_q     <= 1'b1;
			pass_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_pend_q <= 1'b0;
			if (rd_pend_q) begin
				out_valid_q      <= 1'b1;
				out_q.read_value <= inside_s1 ? g_rdata : 8'sd0;
				out_q.run_done   <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_data.mode == ogmc_pkg::MODE_READ)) begin
						rd_pend_q <= 1'b1;
					end
					if (in_fire && (in_data.mode == ogmc_pkg::MODE_RUN)) begin
						if (run_off) begin
							out_valid_q <= 1'b1;
							out_q       <= '{read_value: 8'sd0, run_done: 1'b1};
						end else begin
							state_q <= ST_RUN;
							x_q     <= '0;
							y_q     <= '0;
							k_q     <= '0;
							col_q   <= 1'b0;
							erode_q <= 1'b0;
							first_q <= 1'b1;
							pass_q  <= '0;
						end
					end
				end
				ST_RUN: begin
					if (!last_k) begin
						k_q     <= k_q + PW'(1);
						first_q <= 1'b0;
					end else if (last_x && last_y) begin
						state_q <= ST_DRAIN;
					end else begin
						x_q     <= nx;
						y_q     <= ny;
						k_q     <= lo_n;
						first_q <= 1'b1;
					end
				end
				ST_DRAIN: begin
					x_q     <= '0;
					y_q     <= '0;
					k_q     <= '0;
					first_q <= 1'b1;
					state_q <= ST_RUN;
					if (!col_q) begin
						col_q <= 1'b1;
					end else if (!erode_q) begin
						col_q   <= 1'b0;
						erode_q <= 1'b1;
					end else if (pass_q == close_passes_q - 4'd1) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_q       <= '{read_value: 8'sd0, run_done: 1'b1};
					end else begin
						col_q   <= 1'b0;
						erode_q <= 1'b0;
						pass_q  <= pass_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.mode == ogmc_pkg::MODE_READ) |=> ##1 (out_valid_q && !out_q.run_done))
		else $error("read transfer without result");

	a_off_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_data.mode == ogmc_pkg::MODE_RUN) && run_off |=> (out_valid_q && out_q.run_done))
		else $error("disabled run without done result");

	a_row_no_grid_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) && v_s1 && !col_s1 |-> !g_we)
		else $error("grid written during row sweep");

	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !v_s1)
		else $error("input ready while sweep pipeline busy");

endmodule

`default_nettype wire
